### rtl/core/heater_pid_with_overtemp_guard_defines.svh
// assertion macros for the heater regulator
// used by the top level, expects clk and rst_n in scope
`ifndef HEATER_PID_WITH_OVERTEMP_GUARD_DEFINES_SVH
`define HEATER_PID_WITH_OVERTEMP_GUARD_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define HPG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define HPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/hpg_pkg.sv
// shared types and constants of the heater regulator
// no dependencies
`default_nettype none

package hpg_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_PROP     = 3'd1;
  localparam logic [2:0] REG_INTEG    = 3'd2;
  localparam logic [2:0] REG_DERIV    = 3'd3;
  localparam logic [2:0] REG_ILIMIT   = 3'd4;
  localparam logic [2:0] REG_OVH_LIM  = 3'd5;
  localparam logic [2:0] REG_OVH_RES  = 3'd6;

  // register reset values
  localparam logic [5:0]  TARGET_RST  = 6'd40;
  localparam logic [15:0] PROP_RST    = 16'd2560;
  localparam logic [15:0] INTEG_RST   = 16'd128;
  localparam logic [15:0] DERIV_RST   = 16'd256;
  localparam logic [16:0] ILIMIT_RST  = 17'd80000;
  localparam logic [10:0] OVH_LIM_RST = 11'd800;
  localparam logic [10:0] OVH_RES_RST = 11'd752;

  // accepted target range in whole degrees
  localparam logic [5:0] TARGET_MIN = 6'd35;
  localparam logic [5:0] TARGET_MAX = 6'd48;

  // output scaling: duty = floor((s + 204800) / 409600), 409600 = 2^14 * 25
  localparam int unsigned   ROUND_SHIFT = 14;
  localparam logic [17:0]   ROUND_BIAS  = 18'd204800;
  localparam logic [11:0]   QUOT_TOP    = 12'd2525;  // first value that gives 101
  localparam logic [11:0]   QUOT_SAT    = 12'd2500;  // gives exactly 100
  localparam logic [10:0]   RECIP_25    = 11'd1311;  // ceil(2^15 / 25)
  localparam int unsigned   RECIP_SHIFT = 15;

  // what an item does at the end of the pipeline
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_RUN    = 2'd1,
    MODE_OFF    = 2'd2
  } mode_t;

  // status carried alongside an item through the pipeline
  typedef struct packed {
    mode_t mode;
    logic  overheat;
    logic  dry;
    logic  valid;
  } item_flags_t;

endpackage

`default_nettype wire

### rtl/core/heater_pid_with_overtemp_guard.sv
// heater regulator top level: sample handling, interlocks, pid and duty scaling
// depends on hpg_pkg and heater_pid_with_overtemp_guard_defines.svh
`default_nettype none
`include "heater_pid_with_overtemp_guard_defines.svh"

// Heater regulator with over-temperature and dry-burn interlocks. Every input
// item, sample or control tick, gives one result item. A new item can be taken
// every cycle while no finished result waits on out_stall. Sensor state, the
// over-temperature latch, the integral and the last error all settle in the
// accept cycle, so the next item sees them at once; the three gain multiplies,
// the rounding sum and the divide by 25 follow in three further registered
// stages, and the whole pipeline holds while a finished result waits on
// out_stall. Configuration registers sit on an APB-style port at byte
// address 4*index and the user must write them only while idle (not enforced).
module heater_pid_with_overtemp_guard (
  input  wire                clk,
  input  wire                rst_n,
  // input items
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_kind,
  input  wire signed [11:0]  in_sample_temp,
  input  wire                in_sample_error,
  input  wire                in_water_present,
  input  wire                in_system_running,
  // result items
  output logic               out_valid,
  input  wire                out_stall,
  output logic [6:0]         out_heater_duty,
  output logic               out_heater_on,
  output logic               out_overheat_flag,
  output logic               out_dry_flag,
  output logic [1:0]         out_fault_code,
  output logic               out_reading_valid,
  // configuration
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire  [4:0]         cfg_paddr,
  input  wire  [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // configuration registers
  logic [5:0]  target_r;
  logic [15:0] prop_r, integ_gain_r, deriv_r;
  logic [16:0] ilimit_r;
  logic [10:0] ovh_lim_r, ovh_res_r;

  logic [2:0] cfg_index;
  logic       cfg_wr;
  logic [5:0] cfg_target;

  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_target = cfg_pwdata[5:0];

  // register writes, out-of-range targets are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= hpg_pkg::TARGET_RST;
      prop_r       <= hpg_pkg::PROP_RST;
      integ_gain_r <= hpg_pkg::INTEG_RST;
      deriv_r      <= hpg_pkg::DERIV_RST;
      ilimit_r     <= hpg_pkg::ILIMIT_RST;
      ovh_lim_r    <= hpg_pkg::OVH_LIM_RST;
      ovh_res_r    <= hpg_pkg::OVH_RES_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        hpg_pkg::REG_TARGET: begin
          if (cfg_target >= hpg_pkg::TARGET_MIN && cfg_target <= hpg_pkg::TARGET_MAX)
            target_r <= cfg_target;
        end
        hpg_pkg::REG_PROP:    prop_r       <= cfg_pwdata[15:0];
        hpg_pkg::REG_INTEG:   integ_gain_r <= cfg_pwdata[15:0];
        hpg_pkg::REG_DERIV:   deriv_r      <= cfg_pwdata[15:0];
        hpg_pkg::REG_ILIMIT:  ilimit_r     <= cfg_pwdata[16:0];
        hpg_pkg::REG_OVH_LIM: ovh_lim_r    <= cfg_pwdata[10:0];
        hpg_pkg::REG_OVH_RES: ovh_res_r    <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_index)
      hpg_pkg::REG_TARGET:  cfg_prdata = {26'd0, target_r};
      hpg_pkg::REG_PROP:    cfg_prdata = {16'd0, prop_r};
      hpg_pkg::REG_INTEG:   cfg_prdata = {16'd0, integ_gain_r};
      hpg_pkg::REG_DERIV:   cfg_prdata = {16'd0, deriv_r};
      hpg_pkg::REG_ILIMIT:  cfg_prdata = {15'd0, ilimit_r};
      hpg_pkg::REG_OVH_LIM: cfg_prdata = {21'd0, ovh_lim_r};
      hpg_pkg::REG_OVH_RES: cfg_prdata = {21'd0, ovh_res_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // pipeline control: everything moves together unless a result is stuck
  logic advance, in_accept;
  logic v1_r, v2_r, v3_r, out_valid_r;

  assign advance   = !(out_valid_r && out_stall);
  assign in_stall  = !advance;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // regulator state
  logic [10:0]        held_r;
  logic               temp_valid_r;
  logic               overheat_r;
  logic signed [17:0] integ_r;
  logic signed [13:0] prev_err_r;

  // sample path
  logic        take_sample;
  logic [10:0] held_nxt;
  logic        temp_valid_nxt;
  logic        overheat_nxt;

  always_comb begin
    take_sample    = !in_sample_error && !in_sample_temp[11];
    held_nxt       = take_sample ? in_sample_temp[10:0] : held_r;
    temp_valid_nxt = in_sample_error ? 1'b0 : (take_sample ? 1'b1 : temp_valid_r);
    if (held_nxt >= ovh_lim_r)
      overheat_nxt = 1'b1;
    else if (held_nxt < ovh_res_r && in_water_present)
      overheat_nxt = 1'b0;
    else
      overheat_nxt = overheat_r;
  end

  // tick path: error, clamped integral, error difference
  logic               interlock;
  logic signed [13:0] err;
  logic signed [18:0] acc_raw, lim_pos;
  logic signed [17:0] acc;
  logic signed [14:0] derr;
  logic signed [19:0] err100;
  logic signed [25:0] derr10k;

  always_comb begin
    interlock = !in_system_running || overheat_r || !in_water_present || !temp_valid_r;
    err       = $signed({4'd0, target_r, 4'd0}) - $signed({3'd0, held_r});
    acc_raw   = 19'(integ_r) + 19'(err);
    lim_pos   = $signed({2'd0, ilimit_r});
    if (acc_raw > lim_pos)
      acc = lim_pos[17:0];
    else if (acc_raw < -lim_pos)
      acc = 18'(-lim_pos);
    else
      acc = acc_raw[17:0];
    derr    = 15'(err) - 15'(prev_err_r);
    err100  = 20'(err) * 20'sd100;
    derr10k = 26'(derr) * 26'sd10000;
  end

  // state update at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= 11'd0;
      temp_valid_r <= 1'b0;
      overheat_r   <= 1'b0;
      integ_r      <= 18'sd0;
      prev_err_r   <= 14'sd0;
    end else if (in_accept) begin
      if (!in_kind) begin
        held_r       <= held_nxt;
        temp_valid_r <= temp_valid_nxt;
        overheat_r   <= overheat_nxt;
      end else if (interlock) begin
        integ_r    <= 18'sd0;
        prev_err_r <= 14'sd0;
      end else begin
        integ_r    <= acc;
        prev_err_r <= err;
      end
    end
  end

  // stage 1: operands and flags of the accepted item
  hpg_pkg::item_flags_t f1_nxt, f1_r, f2_r, f3_r;
  logic signed [19:0]   err100_r;
  logic signed [17:0]   acc_r;
  logic signed [25:0]   derr10k_r;

  always_comb begin
    if (!in_kind) begin
      f1_nxt.mode     = hpg_pkg::MODE_SAMPLE;
      f1_nxt.overheat = overheat_nxt;
      f1_nxt.valid    = temp_valid_nxt;
    end else begin
      f1_nxt.mode     = interlock ? hpg_pkg::MODE_OFF : hpg_pkg::MODE_RUN;
      f1_nxt.overheat = overheat_r;
      f1_nxt.valid    = temp_valid_r;
    end
    f1_nxt.dry = !in_water_present;
  end

  // stage 2: gain products
  logic signed [36:0] p_prop;
  logic signed [34:0] p_integ;
  logic signed [42:0] p_deriv;
  logic signed [36:0] p_prop_r;
  logic signed [34:0] p_integ_r;
  logic signed [42:0] p_deriv_r;

  assign p_prop  = $signed({1'b0, prop_r}) * err100_r;
  assign p_integ = $signed({1'b0, integ_gain_r}) * acc_r;
  assign p_deriv = $signed({1'b0, deriv_r}) * derr10k_r;

  // stage 3: rounding sum, drop the 2^14 factor, saturate the quotient
  logic signed [43:0] sum;
  logic signed [29:0] quot;
  logic [11:0]        quot_c, quot_r;

  always_comb begin
    sum  = 44'(p_prop_r) + 44'(p_integ_r) + 44'(p_deriv_r)
         + $signed({26'd0, hpg_pkg::ROUND_BIAS});
    quot = sum[43:hpg_pkg::ROUND_SHIFT];
    if (quot < 0)
      quot_c = 12'd0;
    else if (quot >= $signed({18'd0, hpg_pkg::QUOT_TOP}))
      quot_c = hpg_pkg::QUOT_SAT;
    else
      quot_c = quot[11:0];
  end

  // stage 4: divide by 25 through the reciprocal
  logic [22:0] recip_prod;
  logic [6:0]  duty_calc;

  assign recip_prod = quot_r * hpg_pkg::RECIP_25;
  assign duty_calc  = recip_prod[hpg_pkg::RECIP_SHIFT +: 7];

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      v1_r        <= in_accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_r      <= f1_nxt;
      err100_r  <= err100;
      acc_r     <= acc;
      derr10k_r <= derr10k;
      f2_r      <= f1_r;
      p_prop_r  <= p_prop;
      p_integ_r <= p_integ;
      p_deriv_r <= p_deriv;
      f3_r      <= f2_r;
      quot_r    <= quot_c;
    end
  end

  // result register, the duty it holds doubles as the duty in force
  logic [6:0] duty_r;
  logic       ovh_out_r, dry_out_r, valid_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= 7'd0;
    end else if (advance && v3_r) begin
      case (f3_r.mode)
        hpg_pkg::MODE_RUN: duty_r <= duty_calc;
        hpg_pkg::MODE_OFF: duty_r <= 7'd0;
        default:           duty_r <= duty_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v3_r) begin
      ovh_out_r   <= f3_r.overheat;
      dry_out_r   <= f3_r.dry;
      valid_out_r <= f3_r.valid;
    end
  end

  assign out_heater_duty   = duty_r;
  assign out_heater_on     = (duty_r != 7'd0);
  assign out_overheat_flag = ovh_out_r;
  assign out_dry_flag      = dry_out_r;
  assign out_fault_code    = {dry_out_r, ovh_out_r};
  assign out_reading_valid = valid_out_r;

  // checks
  logic ilk_tick;

  assign ilk_tick = in_accept && in_kind && interlock;

  `HPG_ASSERT_IMP(a_stall_src, in_stall, out_valid_r && out_stall, "stall without result")
  `HPG_ASSERT_IMP(a_quot_in_range, v3_r, quot_r < hpg_pkg::QUOT_TOP, "quotient past saturation")
  `HPG_ASSERT_IMP(a_duty_max, out_valid_r, duty_r <= 7'd100, "duty above 100 percent")
  `HPG_ASSERT_NXT(a_ilk_clears, ilk_tick, integ_r == '0 && prev_err_r == '0, "pid memory kept")

endmodule

`default_nettype wire
